@@ rtl/core/icsn_pkg.sv @@
// Package for the integer cumulative scan core: item types, mode codes and NA marker.
`timescale 1ns / 1ps
`default_nettype none

package icsn_pkg;

  localparam int unsigned ElemWidth = 32;
  localparam int unsigned ModeWidth = 2;

  // Missing-value marker: most negative 32-bit value.
  localparam logic [ElemWidth-1:0] NaValue = {1'b1, {(ElemWidth-1){1'b0}}};

  typedef enum logic [ModeWidth-1:0] {
    MODE_SUM = 2'd0,
    MODE_MAX = 2'd1,
    MODE_MIN = 2'd2
  } scan_mode_e;

  typedef struct packed {
    logic signed [ElemWidth-1:0] element;
    logic                        end_of_vector;
  } in_item_t;

  typedef struct packed {
    logic signed [ElemWidth-1:0] running_value;
    logic                        overflow_seen;
    logic                        end_of_run;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/int_cumulative_scan_na_core.sv @@
// Top level of the integer cumulative scan core (sum, max, min with NA handling).
`timescale 1ns / 1ps
`default_nettype none

// Running prefix scan over signed 32-bit elements, one result item per input item.
// The value -2147483648 is NA; once it arrives, the rest of the vector gives NA.
// cfg_data_i selects sum, max or min (code 3 gives NA and leaves the state alone);
// write it only while the core is idle. In sum mode a running sum beyond
// +-(2^31-1) flags overflow_seen on that item and the vector gives NA afterwards.
// An item with end_of_vector set restarts the scan after its own result.
// Throughput is one item per clock while out_stall_i is low: the accumulator update is
// one 33-bit add or one compare between the input register and the accumulator
// register. An accepted input item passes through the input register and then the
// result register, and waits in the input register while a stalled result holds it.
module int_cumulative_scan_na_core
  import icsn_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [ModeWidth-1:0] cfg_data_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_item_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_item_o
);

  logic [ModeWidth-1:0] mode_q;

  logic     s1_valid_q;
  in_item_t s1_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic [ElemWidth-1:0] acc_q, acc_d;
  logic                 halted_q, halted_d;
  logic                 first_q, first_d;

  logic      s1_fire;
  logic      in_fire;
  out_item_t res;

  logic signed [ElemWidth:0] sum_ext;
  logic                      sum_ovf;
  logic                      elem_gt;
  logic                      elem_lt;
  logic [ElemWidth-1:0]      pick;

  // stage 1 moves into the result register when that register is free or draining
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign sum_ext = {acc_q[ElemWidth-1], acc_q} + {s1_q.element[ElemWidth-1], s1_q.element};
  // out of 32-bit range, or landed exactly on the NA code
  assign sum_ovf = (sum_ext[ElemWidth] != sum_ext[ElemWidth-1])
                   || (sum_ext[ElemWidth-1:0] == NaValue);
  assign elem_gt = $signed(s1_q.element) > $signed(acc_q);
  assign elem_lt = $signed(s1_q.element) < $signed(acc_q);

  always_comb begin
    acc_d    = acc_q;
    halted_d = halted_q;
    first_d  = first_q;
    res.running_value = NaValue;
    res.overflow_seen = 1'b0;
    res.end_of_run    = s1_q.end_of_vector;
    pick = acc_q;

    if (!halted_q) begin
      case (mode_q)
        MODE_SUM: begin
          if (s1_q.element == NaValue) begin
            halted_d = 1'b1;
          end else if (sum_ovf) begin
            halted_d          = 1'b1;
            res.overflow_seen = 1'b1;
          end else begin
            acc_d             = sum_ext[ElemWidth-1:0];
            first_d           = 1'b0;
            res.running_value = sum_ext[ElemWidth-1:0];
          end
        end
        MODE_MAX, MODE_MIN: begin
          if (s1_q.element == NaValue) begin
            halted_d = 1'b1;
          end else begin
            if (first_q) begin
              pick = s1_q.element;
            end else if (mode_q == MODE_MAX) begin
              pick = elem_gt ? s1_q.element : acc_q;
            end else begin
              pick = elem_lt ? s1_q.element : acc_q;
            end
            acc_d             = pick;
            first_d           = 1'b0;
            res.running_value = pick;
          end
        end
        default: begin
          res.running_value = NaValue;
        end
      endcase
    end

    if (s1_q.end_of_vector) begin
      acc_d    = '0;
      halted_d = 1'b0;
      first_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SUM;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      halted_q    <= 1'b0;
      first_q     <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        acc_q       <= acc_d;
        halted_q    <= halted_d;
        first_q     <= first_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_item_i;
    end
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // overflow is only reported on an NA result
  a_ovf_is_na: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.overflow_seen |-> out_q.running_value == NaValue)
    else $error("overflow flagged on a non-NA result");

  // overflow comes from sum mode only
  a_ovf_sum_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.overflow_seen |-> mode_q == MODE_SUM)
    else $error("overflow flagged outside sum mode");

  // the end mark restarts the scan
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_q.end_of_vector |=> !halted_q && first_q && acc_q == '0)
    else $error("scan state not restarted after end of vector");

  // a halted scan gives plain NA
  a_halted_na: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && halted_q |=> out_q.running_value == NaValue && !out_q.overflow_seen)
    else $error("halted scan produced a value");

endmodule

`default_nettype wire
